// ===== rtl/fpsf_pkg.sv =====
// package for the five-point stencil filter
// widths, reset values, register indexes and divide-by-ten constants
// no dependencies
package fpsf_pkg;

    localparam int PIXEL_BITS      = 16;
    localparam int SUM_BITS        = PIXEL_BITS + 4;
    localparam int WIDTH_CFG_BITS  = 11;
    localparam int HEIGHT_CFG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_INDEX_BITS  = 1;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [WIDTH_CFG_BITS-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_CFG_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd1024;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // rounding offset and reciprocal of ten for the sum
    localparam logic [SUM_BITS-1:0] ROUND_OFFSET = SUM_BITS'(5);
    localparam int DIV10_SHIFT = SUM_BITS + 3;
    localparam logic [SUM_BITS-1:0] DIV10_RECIP =
        SUM_BITS'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                last;
    } sum_word_t;

endpackage

// ===== rtl/fpsf_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module fpsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fpsf_window.sv =====
// raster counters, line store and neighbor window, stencil sum register
// depends on fpsf_pkg and fpsf_ram
module fpsf_window #(
    parameter int MAX_WIDTH  = fpsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fpsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [fpsf_pkg::WIDTH_CFG_BITS-1:0]    image_width,
    input  logic [fpsf_pkg::HEIGHT_CFG_BITS-1:0]   image_height,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  logic [fpsf_pkg::PIXEL_BITS-1:0]        pixel_in,
    input  logic                                   pad_row,
    output logic                                   sum_valid,
    input  logic                                   sum_stall,
    output fpsf_pkg::sum_word_t                    sum_word
);

    localparam int PB  = fpsf_pkg::PIXEL_BITS;
    localparam int SB  = fpsf_pkg::SUM_BITS;
    localparam int EW  = 2 * PB;
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (WW > fpsf_pkg::WIDTH_CFG_BITS) ? WW : fpsf_pkg::WIDTH_CFG_BITS;
    localparam int HCW = (RW > fpsf_pkg::HEIGHT_CFG_BITS) ? RW : fpsf_pkg::HEIGHT_CFG_BITS;

    logic [AW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           use_ram_reg, use_ram_next;
    logic           fix_reg, fix_next;
    logic [EW-1:0]  cur_reg, nxt_reg, head0_reg, head1_reg;
    logic [PB-1:0]  left_reg;
    logic           sum_valid_reg;
    fpsf_pkg::sum_word_t sum_word_reg;

    logic [WCW-1:0] w_cfg;
    logic [HCW-1:0] h_cfg;
    logic [WW-1:0]  w_eff, w_m1, col_ext, c_full;
    logic [RW-1:0]  h_eff;
    logic [AW-1:0]  c;
    logic [WW:0]    c_plus2;
    logic           row_end, overrun, is_pad, accept, s1_move, produce;
    logic [PB-1:0]  px, center, top, left, right;
    logic [EW-1:0]  nxt_word, cur_word, wr_word, ram_rd_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [SB-1:0]  sum;

    // effective geometry
    always_comb
    begin
        w_cfg = WCW'(image_width);
        if (w_cfg < WCW'(2))
        begin
            w_eff = WW'(2);
        end
        else if (w_cfg > WCW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_cfg[WW-1:0];
        end

        h_cfg = HCW'(image_height);
        if (h_cfg == '0)
        begin
            h_eff = RW'(1);
        end
        else if (h_cfg > HCW'(MAX_HEIGHT))
        begin
            h_eff = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_cfg[RW-1:0];
        end
    end

    assign w_m1    = w_eff - WW'(1);
    assign col_ext = WW'(col_reg);
    assign row_end = (col_ext >= w_m1);
    assign overrun = (col_ext > w_m1);
    assign c_full  = row_end ? w_m1 : col_ext;
    assign c       = c_full[AW-1:0];
    assign is_pad  = (row_reg >= h_eff);
    assign produce = (row_reg != '0);

    // a column left beyond the last one stalls while its entry is read from the line store
    assign s1_move     = !sum_valid_reg || !sum_stall;
    assign pixel_stall = !s1_move || (overrun && !fix_reg);
    assign accept      = pixel_valid && !pixel_stall;

    // window taps
    assign nxt_word = use_ram_reg ? ram_rd_data : nxt_reg;
    assign cur_word = fix_reg ? ram_rd_data : cur_reg;
    assign px       = (is_pad || pad_row) ? '0 : pixel_in;
    assign center   = cur_word[PB-1:0];
    assign top      = (row_reg == RW'(1)) ? '0 : cur_word[EW-1:PB];
    assign right    = row_end ? '0 : nxt_word[PB-1:0];
    assign left     = (c_full == '0) ? '0 : left_reg;
    assign wr_word  = {center, px};

    assign sum = (SB'(center) << 2) + (SB'(center) << 1) + SB'(top) + SB'(px)
               + SB'(left) + SB'(right) + fpsf_pkg::ROUND_OFFSET;

    // one column of lookahead on the read port
    assign c_plus2 = (WW + 1)'(c_full) + (WW + 1)'(2);
    assign rd_en   = (accept && !row_end && (c_plus2 < (WW + 1)'(w_eff)))
                   || (overrun && !fix_reg);
    assign rd_addr = overrun ? c : c_plus2[AW-1:0];

    fpsf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (c),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        use_ram_next = use_ram_reg;
        fix_next     = overrun && !accept;
        if (accept)
        begin
            if (row_end)
            begin
                col_next     = '0;
                row_next     = is_pad ? '0 : row_reg + RW'(1);
                use_ram_next = 1'b0;
            end
            else
            begin
                col_next     = AW'(c_full + WW'(1));
                use_ram_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            use_ram_reg   <= 1'b0;
            fix_reg       <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            use_ram_reg <= use_ram_next;
            fix_reg     <= fix_next;
            if (s1_move)
            begin
                sum_valid_reg <= accept && produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (c_full == '0)
            begin
                head0_reg <= wr_word;
            end
            if (c_full == WW'(1))
            begin
                head1_reg <= wr_word;
            end
            if (row_end)
            begin
                cur_reg  <= head0_reg;
                nxt_reg  <= (c_full == WW'(1)) ? wr_word : head1_reg;
                left_reg <= '0;
            end
            else
            begin
                cur_reg  <= nxt_word;
                left_reg <= center;
            end
            sum_word_reg.sum  <= sum;
            sum_word_reg.last <= is_pad && row_end;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_word  = sum_word_reg;

endmodule

// ===== rtl/fpsf_div10.sv =====
// rounded divide by ten of the stencil sum and the result output register
// depends on fpsf_pkg
module fpsf_div10 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sum_valid,
    output logic                            sum_stall,
    input  fpsf_pkg::sum_word_t             sum_word,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [fpsf_pkg::PIXEL_BITS-1:0] pixel_out,
    output logic                            frame_last
);

    localparam int PB = fpsf_pkg::PIXEL_BITS;
    localparam int SB = fpsf_pkg::SUM_BITS;
    localparam int SH = fpsf_pkg::DIV10_SHIFT;

    logic            prod_valid_reg;
    logic [2*SB-1:0] prod_reg;
    logic            prod_last_reg;
    logic            result_valid_reg;
    logic [PB-1:0]   pixel_out_reg;
    logic            frame_last_reg;

    logic            out_move, prod_move;
    logic [2*SB-1:0] prod_next;

    assign out_move  = !result_valid_reg || !result_stall;
    assign prod_move = !prod_valid_reg || out_move;
    assign sum_stall = !prod_move;

    assign prod_next = {SB'(0), sum_word.sum} * {SB'(0), fpsf_pkg::DIV10_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (prod_move)
            begin
                prod_valid_reg <= sum_valid;
            end
            if (out_move)
            begin
                result_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_move && sum_valid)
        begin
            prod_reg      <= prod_next;
            prod_last_reg <= sum_word.last;
        end
        if (out_move && prod_valid_reg)
        begin
            pixel_out_reg  <= prod_reg[SH+PB-1:SH];
            frame_last_reg <= prod_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign frame_last   = frame_last_reg;

endmodule

// ===== rtl/five_point_stencil_filter_core.sv =====
// five-point stencil filter core, 3 stages: stencil sum registered at the edge that
// accepts the word of the row below, then product and result word; one word per cycle
// when not stalled, set by the single read port of the line store read one column ahead;
// a column beyond the last after a mid-row width change stalls while its entry is read.
// reset clears counters, config to 1024 x 1024 and the pipeline valids; line store
// contents stay undefined, no clearing pass. depends on fpsf_pkg, fpsf_window, fpsf_div10
module five_point_stencil_filter_core #(
    parameter int MAX_WIDTH  = fpsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fpsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fpsf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fpsf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [fpsf_pkg::PIXEL_BITS-1:0]     pixel_in,
    input  logic                                pad_row,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [fpsf_pkg::PIXEL_BITS-1:0]     pixel_out,
    output logic                                frame_last
);

    logic [fpsf_pkg::WIDTH_CFG_BITS-1:0]  image_width_reg;
    logic [fpsf_pkg::HEIGHT_CFG_BITS-1:0] image_height_reg;

    logic                sum_valid;
    logic                sum_stall;
    fpsf_pkg::sum_word_t sum_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= fpsf_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= fpsf_pkg::IMAGE_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fpsf_pkg::CFG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data[fpsf_pkg::WIDTH_CFG_BITS-1:0];
                end
                fpsf_pkg::CFG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data[fpsf_pkg::HEIGHT_CFG_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    fpsf_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_in     (pixel_in),
        .pad_row      (pad_row),
        .sum_valid    (sum_valid),
        .sum_stall    (sum_stall),
        .sum_word     (sum_word)
    );

    fpsf_div10 u_div10 (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum_stall    (sum_stall),
        .sum_word     (sum_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_out    (pixel_out),
        .frame_last   (frame_last)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for five_point_stencil_filter_core: streams raster frames of many sizes,
// predicts each filtered word as its pixel is taken and checks results in order
// depends on fpsf_pkg and the core
module tb_top;

    localparam int PB   = fpsf_pkg::PIXEL_BITS;
    localparam int CDB  = fpsf_pkg::CFG_DATA_BITS;
    localparam int CIB  = fpsf_pkg::CFG_INDEX_BITS;
    localparam int WCB  = fpsf_pkg::WIDTH_CFG_BITS;
    localparam int HCB  = fpsf_pkg::HEIGHT_CFG_BITS;
    localparam int MAXW = fpsf_pkg::MAX_WIDTH_DEF;
    localparam int MAXH = fpsf_pkg::MAX_HEIGHT_DEF;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [PB-1:0] pix;
        logic          last;
    } result_word_t;

    typedef struct {
        bit             new_frame;
        logic [CDB-1:0] width_data;
        logic [CDB-1:0] height_data;
        logic [PB-1:0]  pix;
        logic           pad;
        bit             typed;
        logic [PB-1:0]  exp_pix;
        logic           exp_last;
    } directed_row_t;

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           cfg_wr_en    = 1'b0;
    logic [CIB-1:0] cfg_index    = fpsf_pkg::CFG_IMAGE_WIDTH;
    logic [CDB-1:0] cfg_data     = '0;
    logic           pixel_valid  = 1'b0;
    logic [PB-1:0]  pixel_in     = '0;
    logic           pad_row      = 1'b0;
    logic           result_stall = 1'b0;
    logic           pixel_stall;
    logic           result_valid;
    logic [PB-1:0]  pixel_out;
    logic           frame_last;

    // filter state
    logic [WCB-1:0] width_reg;
    logic [HCB-1:0] height_reg;
    logic [PB-1:0]  line_above [MAXW];
    logic [PB-1:0]  line_two_above [MAXW];
    logic [PB-1:0]  left_center;
    int             col_pos;
    int             row_pos;

    result_word_t expected_results [$];
    int  error_count;
    int  results_seen;
    int  idle_cycles;
    int  random_items;
    bit  gaps_on;

    // frame a: clamped 2 x 1, all zero; frame b: 2 x 1 at full scale;
    // frame c: 3 x 3 with masked width bits, full scale center and a zeroed word
    directed_row_t dir_table [20] = '{
        '{1, 13'd0,     13'd0, 16'h0000, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'h0000, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b1, 1, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b1, 1, 16'h0000, 1'b1},
        '{1, 13'd1,     13'd1, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 1, 16'd45875, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 1, 16'd45875, 1'b1},
        '{1, 13'h1803,  13'd3, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b0, 1, 16'hffff, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b1, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'hffff, 1'b1, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'h1234, 1'b0, 0, 16'h0000, 1'b0},
        '{0, 13'd0,     13'd0, 16'h1234, 1'b0, 0, 16'h0000, 1'b0}
    };

    five_point_stencil_filter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_in     (pixel_in),
        .pad_row      (pad_row),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_out    (pixel_out),
        .frame_last   (frame_last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > MAXH) h = MAXH;
        return h;
    endfunction

    // one pixel in, filtered word of the row above out
    function automatic bit stencil_step(input logic [PB-1:0] pix, input logic pad,
                                        output result_word_t res);
        int w;
        int h;
        int c;
        int sum;
        bit is_pad;
        bit row_end;
        bit produced;
        logic [PB-1:0] px;
        logic [PB-1:0] center;
        logic [PB-1:0] top;
        logic [PB-1:0] right;
        logic [PB-1:0] left;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        is_pad = row_pos >= h;
        if (c >= w) c = w - 1;
        row_end = c >= w - 1;
        px = (is_pad || pad) ? '0 : pix;
        center = line_above[c];
        top = (row_pos == 1) ? '0 : line_two_above[c];
        right = row_end ? '0 : line_above[c + 1];
        left = (c == 0) ? '0 : left_center;
        produced = row_pos >= 1;
        sum = 6 * int'(center) + int'(top) + int'(px) + int'(left) + int'(right) + 5;
        res.pix = PB'(sum / 10);
        res.last = is_pad && row_end;
        left_center = center;
        line_two_above[c] = center;
        line_above[c] = px;
        if (row_end)
        begin
            col_pos = 0;
            left_center = '0;
            row_pos = is_pad ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
        return produced;
    endfunction

    task automatic wait_drained();
        pixel_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_geometry(input logic [CDB-1:0] wd, input logic [CDB-1:0] hd);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= fpsf_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= wd;
        @(posedge clk);
        width_reg = wd[WCB-1:0];
        cfg_index <= fpsf_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= hd;
        @(posedge clk);
        height_reg = hd[HCB-1:0];
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PB-1:0] pix, input logic pad,
                              input bit typed, input logic [PB-1:0] typed_pix,
                              input logic typed_last);
        int gap;
        int roll;
        bit produced;
        result_word_t res;
        gap = 0;
        if (gaps_on)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 92) gap = $urandom_range(10, 40);
            else if (roll >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_in <= pix;
        pad_row <= pad;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        produced = stencil_step(pix, pad, res);
        if (typed)
        begin
            res.pix = typed_pix;
            res.last = typed_last;
        end
        if (produced) expected_results.push_back(res);
    endtask

    task automatic run_frame(input logic [CDB-1:0] wd, input logic [CDB-1:0] hd,
                             input bit counted);
        int w;
        int h;
        int roll;
        logic [PB-1:0] pix;
        logic pad;
        write_geometry(wd, hd);
        w = eff_width();
        h = eff_height();
        gaps_on = $urandom_range(0, 3) != 0;
        for (int r = 0; r <= h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                roll = $urandom_range(0, 7);
                if (roll == 0) pix = '0;
                else if (roll == 1) pix = '1;
                else pix = PB'($urandom_range(0, 65535));
                if (r == h) pad = 1'($urandom_range(0, 1));
                else pad = $urandom_range(0, 15) == 0;
                send_pixel(pix, pad, 0, '0, 1'b0);
            end
        end
        if (counted) random_items += (h + 1) * w;
    endtask

    // result check and watchdog
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, actual %h last %b",
                             $time, pixel_out, frame_last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (pixel_out !== want.pix)
                    begin
                        error_count++;
                        $display("%0t: pixel_out expected %h actual %h",
                                 $time, want.pix, pixel_out);
                    end
                    if (frame_last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: frame_last expected %b actual %b",
                                 $time, want.last, frame_last);
                    end
                end
            end
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // output back-pressure
    initial
    begin
        int hold;
        int pause;
        bit pressure_done;
        pressure_done = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = 0;
            if (!pressure_done && results_seen >= 100 && pixel_valid)
            begin
                hold = HOLD_CYCLES;
                pressure_done = 1;
            end
            else if ($urandom_range(0, 9) < 4)
            begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            pause = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 6);
            repeat (pause) @(posedge clk);
        end
    end

    initial
    begin
        int frame_idx;
        logic [CDB-1:0] wd;
        logic [CDB-1:0] hd;
        width_reg = fpsf_pkg::IMAGE_WIDTH_RESET;
        height_reg = fpsf_pkg::IMAGE_HEIGHT_RESET;
        for (int i = 0; i < MAXW; i++)
        begin
            line_above[i] = '0;
            line_two_above[i] = '0;
        end
        left_center = '0;
        col_pos = 0;
        row_pos = 0;
        error_count = 0;
        results_seen = 0;
        idle_cycles = 0;
        random_items = 0;
        gaps_on = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            if (dir_table[i].new_frame)
                write_geometry(dir_table[i].width_data, dir_table[i].height_data);
            send_pixel(dir_table[i].pix, dir_table[i].pad, dir_table[i].typed,
                       dir_table[i].exp_pix, dir_table[i].exp_last);
        end

        frame_idx = 0;
        while (random_items < RANDOM_ITEMS || frame_idx < 6)
        begin
            case (frame_idx)
                1: run_frame(13'h1802, 13'd0, 1);
                3: run_frame(13'd64, 13'd1, 1);
                5: run_frame(13'd2, 13'd20, 1);
                default:
                begin
                    if ($urandom_range(0, 15) == 0) wd = CDB'($urandom_range(0, 1));
                    else if ($urandom_range(0, 7) == 0) wd = CDB'($urandom_range(13, 64));
                    else wd = CDB'($urandom_range(2, 12));
                    wd = wd | (CDB'($urandom_range(0, 3)) << 11);
                    if ($urandom_range(0, 9) == 0) hd = '0;
                    else if ($urandom_range(0, 7) == 0) hd = CDB'($urandom_range(7, 20));
                    else hd = CDB'($urandom_range(1, 6));
                    run_frame(wd, hd, 1);
                end
            endcase
            frame_idx++;
        end

        wait_drained();
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
